[design/isl_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// isl_pkg: shared types and constants for the indexed shift list
// Operation and status codes, per-cell control, fixed field widths.
// ============================================================================
package isl_pkg;

    // Fixed widths of the channel fields
    localparam int MODE_BITS   = 3;
    localparam int POS_IN_BITS = 9;
    localparam int VALUE_BITS  = 64;
    localparam int COUNT_BITS  = 9;
    localparam int STATUS_BITS = 2;

    // Cell index width, covers up to 4096 cells
    localparam int POS_BITS = 12;

    // Cells per first-level group of the read tree
    localparam int GROUP = 16;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_GET    = 3'd2,
        MODE_SET    = 3'd3,
        MODE_PUSH   = 3'd4,
        MODE_POP    = 3'd5
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Broadcast cell operation
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_INS   = 2'd1,
        CELL_DEL   = 2'd2,
        CELL_WRITE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [POS_BITS-1:0] pos;
        logic                rd;
    } cell_ctrl_t;

endpackage

[design/isl_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// isl_req_if / isl_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ============================================================================
interface isl_req_if
    import isl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [MODE_BITS-1:0]   mode;
    logic [POS_IN_BITS-1:0] position;
    logic [VALUE_BITS-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface isl_rsp_if
    import isl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0]  count;
    logic [STATUS_BITS-1:0] status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

[design/isl_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// isl_cell: one list entry
// Holds one word; loads from its lower neighbor, upper neighbor or the input.
// ============================================================================
module isl_cell
    import isl_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [WORD_BITS-1:0] left,
    input  logic [WORD_BITS-1:0] right,
    input  logic [WORD_BITS-1:0] value,
    output logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] tap
);

    localparam logic [POS_BITS-1:0] IDX = POS_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 hit;

    assign hit = (ctrl.pos == IDX);

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (hit)
                    word_next = value;
                else if (IDX > ctrl.pos)
                    word_next = left;
            end
            CELL_DEL:
            begin
                if (IDX >= ctrl.pos)
                    word_next = right;
            end
            CELL_WRITE:
            begin
                if (hit)
                    word_next = value;
            end
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // read tap: only the addressed cell drives nonzero
    assign tap  = (ctrl.rd && hit) ? word_reg : '0;

endmodule

[design/indexed_shift_list.sv]
`timescale 1ns / 1ps
// ============================================================================
// indexed_shift_list: ordered list of words with insert/remove at any index
// Row of cells that all shift together; registered OR tree for reads.
// ============================================================================
// The list lives in a row of CAPACITY cells, one word each. An accepted
// request is decoded against the current count in the same cycle and the
// resulting shift, write or hold is broadcast to every cell, so the whole row
// moves at the accepting clock edge: insert shifts entries above the position
// up by one, remove shifts them down, set rewrites one cell. A request can be
// accepted every cycle unless intake is stalled. Each request gives exactly
// one response, registered first in the first level of the read tree (groups
// of 16 cells), then in the final OR into the output register. A held
// response stalls intake only once a second request is waiting behind it.
// Failed requests (insert or push when full, position out of range, pop when
// empty, unused mode codes) leave the list untouched and return a zero word.
// Entries above the count hold stale data.
// ============================================================================
module indexed_shift_list
    import isl_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int WORD_BITS = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    isl_req_if.sink  req,
    isl_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + POS_IN_BITS;
    localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // ---------------------------------------------------------------- control
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 s1_valid_reg;
    logic [CNT_W-1:0]     s1_count_reg;
    status_t              s1_status_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_value_reg;
    logic [CNT_W-1:0]     out_count_reg;
    status_t              out_status_reg;

    logic                 in_fire;
    logic                 advance;
    status_t              status_next;
    cell_ctrl_t           ctrl;
    logic [CMP_W-1:0]     pos_w;
    logic [CMP_W-1:0]     cnt_w;
    logic [WORD_BITS-1:0] wr_value;

    // stage 1 moves on when the output register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign in_fire  = req.valid && req.ready;

    assign pos_w    = CMP_W'(req.position);
    assign cnt_w    = CMP_W'(cnt_reg);
    assign wr_value = req.value[WORD_BITS-1:0];

    // Decode the request against the current count
    always_comb
    begin
        status_next = ST_BAD;
        cnt_next    = cnt_reg;
        ctrl.op     = CELL_HOLD;
        ctrl.pos    = POS_BITS'(req.position);
        ctrl.rd     = 1'b0;
        case (mode_t'(req.mode))
            MODE_INSERT:
            begin
                if (cnt_reg == CAP_CNT)
                    status_next = ST_FULL;
                else if (pos_w <= cnt_w)
                begin
                    status_next = ST_OK;
                    ctrl.op     = CELL_INS;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (pos_w < cnt_w)
                begin
                    status_next = ST_OK;
                    ctrl.op     = CELL_DEL;
                    ctrl.rd     = 1'b1;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            MODE_GET:
            begin
                if (pos_w < cnt_w)
                begin
                    status_next = ST_OK;
                    ctrl.rd     = 1'b1;
                end
            end
            MODE_SET:
            begin
                if (pos_w < cnt_w)
                begin
                    status_next = ST_OK;
                    ctrl.op     = CELL_WRITE;
                end
            end
            MODE_PUSH:
            begin
                if (cnt_reg == CAP_CNT)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    ctrl.op     = CELL_INS;
                    ctrl.pos    = POS_BITS'(cnt_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            MODE_POP:
            begin
                if (cnt_reg != '0)
                begin
                    status_next = ST_OK;
                    ctrl.op     = CELL_DEL;
                    ctrl.rd     = 1'b1;
                    ctrl.pos    = POS_BITS'(cnt_reg - 1'b1);
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            default:
                status_next = ST_BAD;
        endcase
        // nothing moves without a transfer
        if (!in_fire)
        begin
            ctrl.op = CELL_HOLD;
            ctrl.rd = 1'b0;
        end
    end

    // ------------------------------------------------------------ cell row
    logic [WORD_BITS-1:0] words [CAPACITY];
    logic [WORD_BITS-1:0] taps  [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end

        isl_cell #(
            .INDEX     (i),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .value (wr_value),
            .word  (words[i]),
            .tap   (taps[i])
        );
    end

    // ------------------------------------------------------------ read tree
    logic [WORD_BITS-1:0] grp_reg  [NGRP];
    logic [WORD_BITS-1:0] grp_next [NGRP];
    logic [WORD_BITS-1:0] rd_word;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CAPACITY)
                    grp_next[g] = grp_next[g] | taps[g * GROUP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        rd_word = '0;
        for (int g = 0; g < NGRP; g++)
            rd_word = rd_word | grp_reg[g];
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                cnt_reg <= cnt_next;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_count_reg  <= cnt_next;
            s1_status_reg <= status_next;
        end
        if (advance)
        begin
            out_value_reg  <= rd_word;
            out_count_reg  <= s1_count_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = VALUE_BITS'(out_value_reg);
    assign rsp.count      = COUNT_BITS'(out_count_reg);
    assign rsp.status     = out_status_reg;

endmodule
